### sv/ptl_pkg.sv
// Shared types and constants for the primitive-to-triangle-list assembler.
// No dependencies; used by every module of the block.
`default_nettype none

package ptl_pkg;

  localparam int BUFFER_CAPACITY = 65536;
  localparam int SLOT_W          = $clog2(BUFFER_CAPACITY);
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [1:0] {
    MODE_PASS    = 2'd0,
    MODE_POLYGON = 2'd1,
    MODE_QUADS   = 2'd2,
    MODE_STRIP   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] s;
    logic [31:0] t;
    logic [31:0] rgba;
  } vertex_t;

  // One command per input vertex: the vertex, the two duplicates that may
  // precede it, and the first slot that the run occupies.
  typedef struct packed {
    vertex_t             vert;
    vertex_t             dup_a;
    vertex_t             dup_b;
    logic [SLOT_W-1:0]   slot;
    logic                dup;
    logic                drop;
  } cmd_t;

endpackage

`default_nettype wire

### sv/primitive_to_triangle_list_core.sv
// Primitive assembler top: vertices in, triangle-list vertices out.
// Accepted items pass through the command queue, then into the output register.
// Throughput: one item per cycle for items with one result or none, while the output
// is not held off; an item that adds two duplicates emits its three vertices in turn.
// Reset (synchronous): mode, slot counter, quad corner, queue and output valid
// clear; vertex history is undefined until written.
`default_nettype none

module primitive_to_triangle_list_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [31:0] pos_x,
  input  wire logic [31:0] pos_y,
  input  wire logic [31:0] pos_z,
  input  wire logic [31:0] tex_s,
  input  wire logic [31:0] tex_t,
  input  wire logic [31:0] color_rgba,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_x,
  output logic [31:0]      out_y,
  output logic [31:0]      out_z,
  output logic [31:0]      out_s,
  output logic [31:0]      out_t,
  output logic [31:0]      out_rgba,
  output logic [15:0]      slot,
  output logic             last_of_run,
  output logic             dropped
);

  ptl_pkg::vertex_t in_vert;
  ptl_pkg::vertex_t out_vert;
  ptl_pkg::cmd_t    push_cmd;
  ptl_pkg::cmd_t    head_cmd;
  logic             q_push, q_ready, q_pop, q_valid;

  always_comb begin
    in_vert.x    = pos_x;
    in_vert.y    = pos_y;
    in_vert.z    = pos_z;
    in_vert.s    = tex_s;
    in_vert.t    = tex_t;
    in_vert.rgba = color_rgba;
  end

  ptl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .in_vert     (in_vert),
    .q_ready     (q_ready),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  ptl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  ptl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_vert  (out_vert),
    .out_slot  (slot),
    .out_last  (last_of_run),
    .out_drop  (dropped)
  );

  assign out_x    = out_vert.x;
  assign out_y    = out_vert.y;
  assign out_z    = out_vert.z;
  assign out_s    = out_vert.s;
  assign out_t    = out_vert.t;
  assign out_rgba = out_vert.rgba;

endmodule

`default_nettype wire

### sv/ptl_front.sv
// Front end: takes input items, keeps slot/anchor/recent state and classifies
// each vertex into one command. Depends on ptl_pkg.
`default_nettype none

module ptl_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_wr_en,
  input  wire logic [1:0]      cfg_wr_data,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            kind,
  input  wire ptl_pkg::vertex_t in_vert,
  input  wire logic            q_ready,
  output logic                 q_push,
  output ptl_pkg::cmd_t        q_cmd
);

  localparam int SW = ptl_pkg::SLOT_W;
  localparam logic [SW:0] CAP_L = (SW + 1)'(ptl_pkg::BUFFER_CAPACITY);

  ptl_pkg::mode_t   mode;
  logic [SW-1:0]    slot_count;
  logic [2:0]       slot_mod6;
  logic [1:0]       quad_corner;
  ptl_pkg::vertex_t anchor;
  ptl_pkg::vertex_t recent0, recent1, recent2;

  logic             accept;
  logic             full;
  logic             room;
  logic             dup;
  logic             set_anchor;
  ptl_pkg::vertex_t dup_a, dup_b;
  logic [3:0]       mod6_sum;
  logic [2:0]       slot_mod6_next;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    full = ((SW + 1)'(slot_count) + (SW + 1)'(1)) >= CAP_L;
    room = (slot_count >= SW'(3)) && (((SW + 1)'(slot_count) + (SW + 1)'(3)) < CAP_L);
    dup   = 1'b0;
    dup_a = anchor;
    dup_b = recent0;
    if (room) begin
      if (mode == ptl_pkg::MODE_POLYGON ||
          (mode == ptl_pkg::MODE_QUADS && quad_corner == 2'd3)) begin
        dup = 1'b1;
      end else if (mode == ptl_pkg::MODE_STRIP && slot_mod6 == 3'd0) begin
        dup   = 1'b1;
        dup_a = recent2;
        dup_b = recent0;
      end else if (mode == ptl_pkg::MODE_STRIP && slot_mod6 == 3'd3) begin
        dup   = 1'b1;
        dup_a = recent0;
        dup_b = recent1;
      end
    end
    set_anchor = (slot_count == '0) ||
                 (mode == ptl_pkg::MODE_QUADS && quad_corner == 2'd0);
    // slot position mod 6 advances by one or three
    mod6_sum = {1'b0, slot_mod6} + (dup ? 4'd3 : 4'd1);
    slot_mod6_next = (mod6_sum >= 4'd6) ? 3'(mod6_sum - 4'd6) : mod6_sum[2:0];
  end

  always_comb begin
    q_push       = accept && !kind;
    q_cmd.vert   = in_vert;
    q_cmd.dup_a  = dup_a;
    q_cmd.dup_b  = dup_b;
    q_cmd.slot   = slot_count;
    q_cmd.dup    = dup && !full;
    q_cmd.drop   = full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= ptl_pkg::MODE_PASS;
      slot_count  <= '0;
      slot_mod6   <= '0;
      quad_corner <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode <= ptl_pkg::mode_t'(cfg_wr_data);
      end
      if (accept) begin
        if (kind) begin
          slot_count  <= '0;
          slot_mod6   <= '0;
          quad_corner <= '0;
        end else if (!full) begin
          slot_count  <= slot_count + (dup ? SW'(3) : SW'(1));
          slot_mod6   <= slot_mod6_next;
          quad_corner <= quad_corner + 2'd1;
        end
      end
    end
  end

  // vertex history, no reset
  always_ff @(posedge clk) begin
    if (accept && !kind && !full) begin
      if (set_anchor) begin
        anchor <= in_vert;
      end
      recent0 <= in_vert;
      if (dup) begin
        recent1 <= dup_b;
        recent2 <= dup_a;
      end else begin
        recent1 <= recent0;
        recent2 <= recent1;
      end
    end
  end

`ifndef SYNTHESIS
  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    (SW + 1)'(slot_count) < CAP_L)
    else $error("slot counter beyond buffer capacity");
`endif

endmodule

`default_nettype wire

### sv/ptl_queue.sv
// Short command queue between front and back ends.
// Depends on ptl_pkg for the command type and depth.
`default_nettype none

module ptl_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire ptl_pkg::cmd_t push_cmd,
  output logic               push_ready,
  input  wire logic          pop,
  output logic               head_valid,
  output ptl_pkg::cmd_t      head_cmd
);

  localparam int D     = ptl_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (D > 1) ? $clog2(D) : 1;
  localparam int CNT_W = $clog2(D + 1);

  ptl_pkg::cmd_t    entries [D];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = count != CNT_W'(D);
  assign head_valid = count != '0;
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(D - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(D - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> push_ready)
    else $error("push into full queue");
`endif

endmodule

`default_nettype wire

### sv/ptl_back.sv
// Back end: walks each command, emitting one vertex per cycle into the
// output register while the output is not stalled. Depends on ptl_pkg.
`default_nettype none

module ptl_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire ptl_pkg::cmd_t q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ptl_pkg::vertex_t   out_vert,
  output logic [15:0]        out_slot,
  output logic               out_last,
  output logic               out_drop
);

  localparam int SW = ptl_pkg::SLOT_W;

  logic [1:0]       step;
  logic             can_load;
  logic             load;
  logic             last;
  ptl_pkg::vertex_t sel_vert;

  always_comb begin
    can_load = !out_valid || out_ready;
    load     = q_valid && can_load;
    last     = !q_cmd.dup || step == 2'd2;
    q_pop    = load && last;
    case (step)
      2'd0:    sel_vert = q_cmd.dup ? q_cmd.dup_a : q_cmd.vert;
      2'd1:    sel_vert = q_cmd.dup_b;
      default: sel_vert = q_cmd.vert;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= last ? 2'd0 : step + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_vert <= sel_vert;
      out_slot <= 16'(q_cmd.slot + SW'(step));
      out_last <= last;
      out_drop <= q_cmd.drop;
    end
  end

`ifndef SYNTHESIS
  // mid-run the head command must still be there
  a_head_held: assert property (@(posedge clk) disable iff (rst)
    step != 2'd0 |-> q_valid && q_cmd.dup)
    else $error("run step without duplicating command at head");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step != 2'd3)
    else $error("run step out of range");

  a_drop_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_drop |-> out_last)
    else $error("dropped vertex not flagged last of run");
`endif

endmodule

`default_nettype wire

### tb/sv/primitive_to_triangle_list_core_tb.sv
// Self-checking testbench for primitive_to_triangle_list_core.
// Drives vertex items in every mode, predicts the emitted triangle-list vertices
// and checks each output item in order. Depends on ptl_pkg and the core only.
`timescale 1ns / 100ps

module primitive_to_triangle_list_core_tb;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_BEGIN  = 1'b1;
  localparam logic [1:0] LAST_CORNER = 2'd3;
  localparam int RANDOM_ITEMS = 450;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PRINT_CAP    = 30;

  typedef struct {
    ptl_pkg::vertex_t vert;
    logic [15:0]      slot_idx;
    logic             last_flag;
    logic             drop_flag;
  } emitted_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = 2'd0;
  logic        in_valid = 1'b0;
  wire logic   in_ready;
  logic        kind = KIND_VERTEX;
  logic [31:0] pos_x = '0;
  logic [31:0] pos_y = '0;
  logic [31:0] pos_z = '0;
  logic [31:0] tex_s = '0;
  logic [31:0] tex_t = '0;
  logic [31:0] color_rgba = '0;
  wire logic        out_valid;
  logic             out_ready = 1'b0;
  wire logic [31:0] out_x, out_y, out_z, out_s, out_t, out_rgba;
  wire logic [15:0] slot;
  wire logic        last_of_run;
  wire logic        dropped;

  // assembler state as predicted
  ptl_pkg::mode_t   model_mode = ptl_pkg::MODE_PASS;
  int unsigned      model_slots = 0;
  logic [1:0]       model_corner = 2'd0;
  ptl_pkg::vertex_t model_anchor = '0;
  ptl_pkg::vertex_t model_recent [3];

  emitted_t pending_out [$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int drops_seen = 0;
  int cycles = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  primitive_to_triangle_list_core DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .tex_s(tex_s), .tex_t(tex_t), .color_rgba(color_rgba),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_s(out_s), .out_t(out_t), .out_rgba(out_rgba),
    .slot(slot), .last_of_run(last_of_run), .dropped(dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d vertices still expected",
               cycles, pending_out.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("ERROR: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("vertex %0d: %s got %h, want %h", results_seen, name, got, want));
  endtask

  // appends one expected vertex at the tail of the queue
  task automatic queue_expected(input ptl_pkg::vertex_t v, input logic [15:0] s,
                                input logic last_flag, input logic drop_flag);
    emitted_t e;
    e.vert      = v;
    e.slot_idx  = s;
    e.last_flag = last_flag;
    e.drop_flag = drop_flag;
    pending_out.insert(pending_out.size(), e);
  endtask

  task automatic store_vertex(input ptl_pkg::vertex_t v, input logic last_flag);
    queue_expected(v, 16'(model_slots), last_flag, 1'b0);
    model_recent[2] = model_recent[1];
    model_recent[1] = model_recent[0];
    model_recent[0] = v;
    model_slots = (model_slots + 1) & 32'h1FFFF;
  endtask

  // Predicts the vertices that one accepted input item emits.
  task automatic assemble_item(input logic k, input ptl_pkg::vertex_t v);
    ptl_pkg::vertex_t da;
    ptl_pkg::vertex_t db;
    logic    use_dup;
    logic    room;
    use_dup = 1'b0;
    da = '0;
    db = '0;
    if (k == KIND_BEGIN) begin
      model_slots = 0;
      model_corner = 2'd0;
    end else if (model_slots + 1 >= ptl_pkg::BUFFER_CAPACITY) begin
      queue_expected(v, 16'(model_slots), 1'b1, 1'b1);
    end else begin
      room = model_slots >= 3 && model_slots + 3 < ptl_pkg::BUFFER_CAPACITY;
      if (room) begin
        if (model_mode == ptl_pkg::MODE_POLYGON ||
            (model_mode == ptl_pkg::MODE_QUADS && model_corner == LAST_CORNER)) begin
          da = model_anchor;
          db = model_recent[0];
          use_dup = 1'b1;
        end else if (model_mode == ptl_pkg::MODE_STRIP && model_slots % 3 == 0) begin
          if (model_slots % 6 == 0) begin
            da = model_recent[2];
            db = model_recent[0];
          end else begin
            da = model_recent[0];
            db = model_recent[1];
          end
          use_dup = 1'b1;
        end
      end
      if (use_dup) begin
        store_vertex(da, 1'b0);
        store_vertex(db, 1'b0);
      end
      if (model_slots == 0 ||
          (model_mode == ptl_pkg::MODE_QUADS && model_corner == 2'd0))
        model_anchor = v;
      store_vertex(v, 1'b1);
      model_corner = model_corner + 2'd1;
    end
  endtask

  function automatic logic [31:0] pick_word();
    int sel;
    sel = $urandom_range(15);
    if (sel == 0) return 32'h0000_0000;
    if (sel == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic ptl_pkg::vertex_t random_vertex();
    ptl_pkg::vertex_t v;
    v.x = pick_word();
    v.y = pick_word();
    v.z = pick_word();
    v.s = pick_word();
    v.t = pick_word();
    v.rgba = pick_word();
    return v;
  endfunction

  function automatic ptl_pkg::vertex_t flat_vertex(input logic [31:0] w);
    ptl_pkg::vertex_t v;
    v = {6{w}};
    return v;
  endfunction

  // Offers one item, holds it until accepted, then predicts its vertices.
  task automatic send_item(input logic k, input ptl_pkg::vertex_t v);
    while (tx_idle_on && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    pos_x      <= v.x;
    pos_y      <= v.y;
    pos_z      <= v.z;
    tex_s      <= v.s;
    tex_t      <= v.t;
    color_rgba <= v.rgba;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    assemble_item(k, v);
  endtask

  task automatic send_vertices(input int n);
    repeat (n) send_item(KIND_VERTEX, random_vertex());
  endtask

  // A begin item emits nothing, so allow a few cycles past the last vertex.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input ptl_pkg::mode_t m);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_mode = m;
  endtask

  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_idle_on) begin
      out_ready <= ($urandom_range(99) >= 26);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    emitted_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (dropped) drops_seen++;
      if (pending_out.size() == 0) begin
        report_error($sformatf("vertex at slot %0d with nothing expected", slot));
      end else begin
        want = pending_out.pop_front();
        check_field("x", out_x, want.vert.x);
        check_field("y", out_y, want.vert.y);
        check_field("z", out_z, want.vert.z);
        check_field("s", out_s, want.vert.s);
        check_field("t", out_t, want.vert.t);
        check_field("rgba", out_rgba, want.vert.rgba);
        check_field("slot", 32'(slot), 32'(want.slot_idx));
        check_field("last_of_run", 32'(last_of_run), 32'(want.last_flag));
        check_field("dropped", 32'(dropped), 32'(want.drop_flag));
      end
    end
  end

  task automatic test_pass_extremes();
    write_mode(ptl_pkg::MODE_PASS);
    send_item(KIND_BEGIN, flat_vertex(32'hFFFF_FFFF));
    send_item(KIND_VERTEX, flat_vertex(32'h0000_0000));
    send_item(KIND_VERTEX, flat_vertex(32'hFFFF_FFFF));
    send_item(KIND_VERTEX, flat_vertex(32'hAAAA_AAAA));
    send_item(KIND_VERTEX, flat_vertex(32'h5555_5555));
  endtask

  task automatic test_polygon_fan();
    write_mode(ptl_pkg::MODE_POLYGON);
    send_item(KIND_BEGIN, random_vertex());
    send_vertices(5);
  endtask

  // fourth corner duplicates, fifth starts a new quad anchor
  task automatic test_quads();
    write_mode(ptl_pkg::MODE_QUADS);
    send_item(KIND_BEGIN, random_vertex());
    send_vertices(6);
  endtask

  // slot 3 and slot 6 take the two different duplicate pairs
  task automatic test_quad_strip();
    write_mode(ptl_pkg::MODE_STRIP);
    send_item(KIND_BEGIN, random_vertex());
    send_vertices(5);
  endtask

  // mid-batch switch leaves the strip off its grid of three
  task automatic test_mode_switch();
    write_mode(ptl_pkg::MODE_PASS);
    send_vertices(1);
    write_mode(ptl_pkg::MODE_STRIP);
    send_vertices(3);
  endtask

  task automatic test_random_batches();
    int             n;
    int             sent_here;
    ptl_pkg::mode_t m;
    sent_here = 0;
    while (sent_here < RANDOM_ITEMS) begin
      if ($urandom_range(3) != 0) begin
        m = ptl_pkg::mode_t'(2'($urandom_range(3)));
        write_mode(m);
      end
      if ($urandom_range(9) < 8) begin
        send_item(KIND_BEGIN, random_vertex());
        sent_here++;
      end
      n = $urandom_range(14, 1);
      repeat (n) begin
        if ($urandom_range(99) < 7) send_item(KIND_BEGIN, random_vertex());
        else send_item(KIND_VERTEX, random_vertex());
        sent_here++;
      end
    end
  endtask

  task automatic test_no_idle_stretch();
    write_mode(ptl_pkg::MODE_QUADS);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_item(KIND_BEGIN, random_vertex());
    send_vertices(60);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // output held off so the block fills and stalls its input
  task automatic test_output_holdoff();
    write_mode(ptl_pkg::MODE_POLYGON);
    tx_idle_on = 1'b0;
    hold_seq++;
    send_item(KIND_BEGIN, random_vertex());
    send_vertices(24);
    tx_idle_on = 1'b1;
    wait_idle();
  endtask

  // Offset by one slot so the polygon fan hits the near-capacity skip,
  // then the buffer-full drop in two modes, then recovery after a begin.
  task automatic test_buffer_full();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    write_mode(ptl_pkg::MODE_PASS);
    send_item(KIND_BEGIN, random_vertex());
    send_vertices(4);
    write_mode(ptl_pkg::MODE_POLYGON);
    while (model_slots < ptl_pkg::BUFFER_CAPACITY - 1)
      send_item(KIND_VERTEX, random_vertex());
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_vertices(3);
    write_mode(ptl_pkg::MODE_STRIP);
    send_vertices(2);
    send_item(KIND_BEGIN, random_vertex());
    send_vertices(4);
  endtask

  initial begin
    model_recent[0] = '0;
    model_recent[1] = '0;
    model_recent[2] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_pass_extremes();
    test_polygon_fan();
    test_quads();
    test_quad_strip();
    test_mode_switch();
    test_random_batches();
    test_no_idle_stretch();
    test_output_holdoff();
    test_buffer_full();

    wait_idle();
    repeat (20) @(posedge clk);
    if (pending_out.size() != 0)
      report_error($sformatf("%0d expected vertices never arrived", pending_out.size()));
    $display("Covered pass, fan, quad and strip modes, mid-batch switches and begins: %0d items,",
             items_sent);
    $display("%0d vertices checked incl. %0d dropped at a full buffer, with output hold-off.",
             results_seen, drops_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
